FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL files of the cache; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/lfu_pkg.sv
// Types and constants shared by the LFU cache modules.
`default_nettype none
package lfu_pkg;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [4:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCAN   = 8'b0000_0010,
      ST_SDRAIN = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_AGE    = 8'b0001_0000,
      ST_ADRAIN = 8'b0010_0000,
      ST_COMMIT = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic age;
      logic commit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic update;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/core/lfu_req_if.sv
// Request channel interface: one get or put item.
`default_nettype none
interface lfu_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic [31:0]       key;
   logic signed [31:0] value;

   modport source (output valid, output op, output key, output value, input ready);
   modport sink (input valid, input op, input key, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lfu_rsp_if.sv
// Response channel interface: one result item per request.
`default_nettype none
interface lfu_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] read_value;
   logic               evicted;

   modport source (output valid, output hit, output read_value, output evicted, input ready);
   modport sink (input valid, input hit, input read_value, input evicted, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lfu_ctrl.sv
// Sequencer of the cache: scan pass, decision, aging pass and commit when an entry changes, response.
`default_nettype none
module lfu_ctrl
   import lfu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // No item is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_SDRAIN;
            end
         end
         ST_SDRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = status.update ? ST_AGE : ST_FINISH;
         end
         ST_AGE: begin
            cmd.age = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_ADRAIN;
            end
         end
         ST_ADRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/lfu_datapath.sv
// Entry storage, scan trackers, replacement decision and response register.
`default_nettype none
module lfu_datapath
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [4:0]         csr_wr_data,
   input  wire logic               req_op,
   input  wire logic [31:0]        req_key,
   input  wire logic signed [31:0] req_value,
   input  wire cmd_type            cmd,
   output status_type              status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_hit,
   output logic signed [31:0]      rsp_read_value,
   output logic                    rsp_evicted
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = (CW > 5) ? CW : 5;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

   logic [31:0]         mem_key   [MAX_ENTRIES];
   logic signed [31:0]  mem_value [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] mem_count [MAX_ENTRIES];
   logic [IW-1:0]       mem_rank  [MAX_ENTRIES];

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [CW-1:0]          used_ff;
   logic [4:0]             cap_ff;
   logic [IW-1:0]          cnt_ff;

   logic               op_ff;
   logic [31:0]        key_ff;
   logic signed [31:0] val_ff;

   logic                  rd_vld_ff, rd_age_ff;
   logic [IW-1:0]         rd_idx_ff;
   logic [31:0]           rd_key_ff;
   logic signed [31:0]    rd_value_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;
   logic [IW-1:0]         rd_rank_ff;

   logic                  hit_ff;
   logic [IW-1:0]         hit_slot_ff;
   logic signed [31:0]    hit_value_ff;
   logic [COUNT_BITS-1:0] hit_count_ff;
   logic [IW-1:0]         hit_rank_ff;
   logic                  free_got_ff;
   logic [IW-1:0]         free_slot_ff;
   logic                  vic_got_ff;
   logic [IW-1:0]         vic_slot_ff;
   logic [COUNT_BITS-1:0] vic_count_ff;
   logic [IW-1:0]         vic_rank_ff;

   logic                  fill_ff;
   logic [IW-1:0]         slot_ff, age_rank_ff;
   logic signed [31:0]    new_value_ff;
   logic [COUNT_BITS-1:0] new_count_ff;
   logic                  res_hit_ff, res_evicted_ff;
   logic signed [31:0]    res_value_ff;

   logic                  rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic signed [31:0]    rsp_value_ff;

   logic                  upd_in, fill_in, res_hit_in, res_evicted_in;
   logic [IW-1:0]         slot_in, age_rank_in;
   logic signed [31:0]    new_value_in, res_value_in;
   logic [COUNT_BITS-1:0] new_count_in;
   logic [KW-1:0]         cap_eff;
   logic                  rd_entry_valid, age_write;

   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign age_write = rd_vld_ff && rd_age_ff && rd_entry_valid &&
                      (rd_idx_ff != slot_ff) && (rd_rank_ff < age_rank_ff);

   always_comb begin
      if (KW'(cap_ff) > KW'(MAX_ENTRIES)) begin
         cap_eff = KW'(MAX_ENTRIES);
      end else begin
         cap_eff = KW'(cap_ff);
      end
   end

   // Replacement decision from the results of the scan pass.
   always_comb begin
      upd_in         = 1'b0;
      fill_in        = 1'b0;
      slot_in        = hit_slot_ff;
      age_rank_in    = hit_rank_ff;
      new_value_in   = val_ff;
      new_count_in   = COUNT_BITS'(1);
      res_hit_in     = 1'b0;
      res_value_in   = '0;
      res_evicted_in = 1'b0;
      if (hit_ff) begin
         upd_in     = 1'b1;
         res_hit_in = 1'b1;
         if (op_ff == OP_GET) begin
            new_value_in = hit_value_ff;
            res_value_in = hit_value_ff;
         end
         if (hit_count_ff == '1) begin
            new_count_in = hit_count_ff;
         end else begin
            new_count_in = hit_count_ff + COUNT_BITS'(1);
         end
      end else if (op_ff == OP_PUT && cap_eff != '0) begin
         if (KW'(used_ff) < cap_eff) begin
            upd_in      = free_got_ff;
            fill_in     = free_got_ff;
            slot_in     = free_slot_ff;
            age_rank_in = IW'(used_ff);
         end else begin
            upd_in         = vic_got_ff;
            res_evicted_in = vic_got_ff;
            slot_in        = vic_slot_ff;
            age_rank_in    = vic_rank_ff;
         end
      end
   end

   // Entry storage: registered read, one write a cycle.
   always_ff @(posedge clock) begin
      if (cmd.scan || cmd.age) begin
         rd_key_ff   <= mem_key[cnt_ff];
         rd_value_ff <= mem_value[cnt_ff];
         rd_count_ff <= mem_count[cnt_ff];
         rd_rank_ff  <= mem_rank[cnt_ff];
      end
      if (cmd.commit) begin
         mem_key[slot_ff]   <= key_ff;
         mem_value[slot_ff] <= new_value_ff;
         mem_count[slot_ff] <= new_count_ff;
         mem_rank[slot_ff]  <= '0;
      end else if (age_write) begin
         mem_rank[rd_idx_ff] <= rd_rank_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= CAPACITY_RESET;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.load || cmd.decide) begin
            cnt_ff <= '0;
         end else if (cmd.scan || cmd.age) begin
            cnt_ff <= cnt_ff + IW'(1);
         end
         rd_vld_ff <= cmd.scan || cmd.age;
         if (cmd.commit) begin
            valid_ff[slot_ff] <= 1'b1;
            if (fill_ff) begin
               used_ff <= used_ff + CW'(1);
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         key_ff      <= req_key;
         val_ff      <= req_value;
         hit_ff      <= 1'b0;
         free_got_ff <= 1'b0;
         vic_got_ff  <= 1'b0;
      end else if (rd_vld_ff && !rd_age_ff) begin
         if (rd_entry_valid) begin
            if (!hit_ff && rd_key_ff == key_ff) begin
               hit_ff       <= 1'b1;
               hit_slot_ff  <= rd_idx_ff;
               hit_value_ff <= rd_value_ff;
               hit_count_ff <= rd_count_ff;
               hit_rank_ff  <= rd_rank_ff;
            end
            // Lowest count wins; among equal counts the oldest rank wins.
            if (!vic_got_ff || rd_count_ff < vic_count_ff ||
                (rd_count_ff == vic_count_ff && rd_rank_ff > vic_rank_ff)) begin
               vic_got_ff   <= 1'b1;
               vic_slot_ff  <= rd_idx_ff;
               vic_count_ff <= rd_count_ff;
               vic_rank_ff  <= rd_rank_ff;
            end
         end else if (!free_got_ff) begin
            free_got_ff  <= 1'b1;
            free_slot_ff <= rd_idx_ff;
         end
      end
      if (cmd.scan || cmd.age) begin
         rd_idx_ff <= cnt_ff;
         rd_age_ff <= cmd.age;
      end
      if (cmd.decide) begin
         fill_ff        <= fill_in;
         slot_ff        <= slot_in;
         age_rank_ff    <= age_rank_in;
         new_value_ff   <= new_value_in;
         new_count_ff   <= new_count_in;
         res_hit_ff     <= res_hit_in;
         res_value_ff   <= res_value_in;
         res_evicted_ff <= res_evicted_in;
      end
      if (cmd.finish) begin
         rsp_hit_ff     <= res_hit_ff;
         rsp_value_ff   <= res_value_ff;
         rsp_evicted_ff <= res_evicted_ff;
      end
   end

   assign status.cnt_last = (cnt_ff == LAST_IDX);
   assign status.update   = upd_in;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

endmodule
`default_nettype wire

FILE: rtl/core/lfu_cache_lru_tiebreak_top.sv
// Top level of the LFU cache with least-recently-used tie break.
// An item that changes an entry goes through a scan pass, a decision, an aging pass over the
// same port and a commit before its result is valid.
// A get miss, or a put miss at capacity zero, skips aging and commit.
// One item at a time: the next is taken in the cycle after the result is loaded, and the result
// is loaded later while an earlier one waits; reset empties the cache.
`default_nettype none
`include "assert_macros.svh"
module lfu_cache_lru_tiebreak_top
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data,
   lfu_req_if.sink         req_ch,
   lfu_rsp_if.source       rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_accept;
   logic       rsp_both;
   logic       rsp_miss;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfu_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_op         (req_ch.op),
      .req_key        (req_ch.key),
      .req_value      (req_ch.value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_hit        (rsp_ch.hit),
      .rsp_read_value (rsp_ch.read_value),
      .rsp_evicted    (rsp_ch.evicted)
   );

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_both   = rsp_ch.hit && rsp_ch.evicted;
   assign rsp_miss   = rsp_ch.valid && !rsp_ch.hit;

   `ASSERT_CLK(a_busy_after_accept, clock, reset, req_accept |=> !req_ch.ready, "double accept")
   `ASSERT_CLK(a_hit_no_evict, clock, reset, rsp_ch.valid |-> !rsp_both, "hit with eviction")
   `ASSERT_CLK(a_miss_zero_value, clock, reset, rsp_miss |-> rsp_ch.read_value == 0, "miss value")

endmodule
`default_nettype wire

FILE: dv/tb_lfu_scoreboard.sv
// Cache predictor and result checker for the LFU cache testbench.
`timescale 1ns / 1ps
package tb_lfu_scoreboard_pkg;
   import lfu_pkg::*;

   typedef struct {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
   } lookup_result_type;

   localparam int ENTRIES   = 16;
   localparam int COUNT_TOP = 65535;

   class lfu_scoreboard;
      bit          slot_valid[ENTRIES];
      logic [31:0] slot_key[ENTRIES];
      logic [31:0] slot_value[ENTRIES];
      int unsigned slot_count[ENTRIES];
      int unsigned slot_age[ENTRIES];
      int unsigned used;
      logic [4:0]  capacity;
      lookup_result_type pending[$];
      int          errors;
      int          checked;
      int          hits;
      int          evictions;

      function new();
         used = 0;
         capacity = CAPACITY_RESET;
         errors = 0;
         checked = 0;
         hits = 0;
         evictions = 0;
         foreach (slot_valid[i]) slot_valid[i] = 0;
      endfunction

      function void touch(int s);
         foreach (slot_valid[i])
            if (i != s && slot_valid[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
         slot_age[s] = 0;
      endfunction

      // Works out the result of one accepted item and updates the cache copy.
      function void note_request(logic op, logic [31:0] key, logic [31:0] value);
         lookup_result_type r;
         int s;
         int unsigned cap;
         r.hit = 0;
         r.read_value = 0;
         r.evicted = 0;
         s = -1;
         cap = (capacity > ENTRIES) ? ENTRIES : capacity;
         for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && slot_valid[i] && slot_key[i] == key) s = i;
         if (s >= 0) begin
            r.hit = 1;
            if (op == OP_GET) r.read_value = slot_value[s];
            else slot_value[s] = value;
            if (slot_count[s] < COUNT_TOP) slot_count[s]++;
            touch(s);
         end else if (op == OP_PUT && cap != 0) begin
            if (used < cap) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (s < 0 && !slot_valid[i]) s = i;
               if (s >= 0) begin
                  slot_valid[s] = 1;
                  slot_age[s] = used;
                  used++;
               end
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i] && (s < 0 || slot_count[i] < slot_count[s] ||
                      (slot_count[i] == slot_count[s] && slot_age[i] > slot_age[s])))
                     s = i;
               end
               if (s >= 0) r.evicted = 1;
            end
            if (s >= 0) begin
               slot_key[s] = key;
               slot_value[s] = value;
               slot_count[s] = 1;
               touch(s);
            end
         end
         pending.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      task check_response(logic hit, logic signed [31:0] read_value, logic evicted);
         lookup_result_type e;
         if (pending.size() == 0) begin
            report("response with nothing outstanding");
            return;
         end
         e = pending.pop_front();
         checked++;
         if (hit) hits++;
         if (evicted) evictions++;
         if (hit !== e.hit) report($sformatf("hit %b, predicted %b", hit, e.hit));
         if (read_value !== e.read_value)
            report($sformatf("read_value %0d, predicted %0d", read_value, e.read_value));
         if (evicted !== e.evicted)
            report($sformatf("evicted %b, predicted %b", evicted, e.evicted));
      endtask
   endclass
endpackage

FILE: dv/tb_lfu_cache_lru_tiebreak_top.sv
// Top of the LFU cache testbench: clock, reset, stimulus and response checking.
`timescale 1ns / 1ps
module tb_lfu_cache_lru_tiebreak_top;
   import lfu_pkg::*;
   import tb_lfu_scoreboard_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;
   int         cycle_count;
   bit         calm;
   int         sent;

   lfu_req_if req_ch ();
   lfu_rsp_if rsp_ch ();
   lfu_scoreboard cache_model;

   lfu_cache_lru_tiebreak_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_ch.sink),
      .rsp_ch     (rsp_ch.source)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 600000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Response side: random stall bursts, checks at the accepting edge.
   initial begin
      int stall;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            cache_model.check_response(rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 18) - 1;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   function automatic logic [31:0] pick_key();
      // Mostly a small key pool so hits and evictions are frequent.
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
         default: return $urandom_range(0, 23);
      endcase
   endfunction

   // Valid stays high after an accepted item until the next send or drain replaces it;
   // the block is busy by then, so nothing is taken twice.
   task automatic send(logic op, logic [31:0] key, logic [31:0] value);
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.op <= op;
      req_ch.key <= key;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      cache_model.note_request(op, key, value);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (cache_model.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_capacity(logic [4:0] cap);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 0;
      cache_model.capacity = cap;
   endtask

   task automatic random_phase(int n);
      repeat (n) send($urandom_range(0, 1), pick_key(), $urandom());
   endtask

   initial begin
      cache_model = new();
      calm = 0;
      sent = 0;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = 0;
      req_ch.valid = 0;
      req_ch.op = OP_GET;
      req_ch.key = 0;
      req_ch.value = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: misses, fills, extremes, hits, update in place, count growth.
      send(OP_GET, 32'h0, 32'h0);
      send(OP_PUT, 32'h0, 32'h8000_0000);
      send(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send(OP_GET, 32'h0, 32'h1234);
      send(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(OP_PUT, 32'h0, 32'hFFFF_FFFF);
      send(OP_GET, 32'h0, 32'h0);
      for (int k = 1; k <= 15; k++) send(OP_PUT, 32'hA5A5_0000 + k, k);
      send(OP_PUT, 32'h5A5A_5A5A, 32'h5555_AAAA);
      send(OP_GET, 32'hA5A5_0001, 32'h0);

      // Capacity zero: puts store nothing, held entries still hit.
      set_capacity(5'd0);
      send(OP_PUT, 32'h0BAD_0000, 32'h1);
      send(OP_GET, 32'h0BAD_0000, 32'h0);
      send(OP_GET, 32'h0, 32'h0);
      // Lowered below entries held, then values above the entry count.
      set_capacity(5'd2);
      random_phase(150);
      set_capacity(5'd31);
      random_phase(150);
      set_capacity(5'd1);
      random_phase(100);
      set_capacity(5'd17);
      random_phase(150);
      set_capacity(5'd0);
      random_phase(50);
      set_capacity(5'd8);
      random_phase(150);
      set_capacity(5'd16);
      random_phase(100);
      calm = 1;
      random_phase(125);

      drain();
      $display("%0d items sent, %0d results checked, %0d hits, %0d evictions",
               sent, cache_model.checked, cache_model.hits, cache_model.evictions);
      $display("capacities 0, 1, 2, 8, 16, 17 and 31 were exercised");
      if (cache_model.errors == 0 && cache_model.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
